[rtl/arm_cube_root_position_drive_assert.svh]
// Assertion macros for the arm cube-root position drive.
// Needs a clock named clk and an active-low reset named rst_n in the including module.
`ifndef ARM_CUBE_ROOT_POSITION_DRIVE_ASSERT_SVH
`define ARM_CUBE_ROOT_POSITION_DRIVE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ACRPD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ACRPD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/acrpd_pkg.sv]
// Shared constants for the arm cube-root position drive.
// No dependencies; imported by arm_cube_root_position_drive, its checker and the testbench.
`default_nettype none

package acrpd_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOOT_TARGET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_TARGET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVERSE_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_CUTOFF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TOLERANCE  = 3'd5;

    // Target select codes
    localparam logic [1:0] SEL_FLOOR    = 2'd0;
    localparam logic [1:0] SEL_SHOOT    = 2'd1;
    localparam logic [1:0] SEL_CLIMB    = 2'd2;
    localparam logic [1:0] SEL_TRAVERSE = 2'd3;

    // Register widths and reset values
    localparam int REG_W = 16;
    localparam int TOL_W = 12;
    localparam logic signed [REG_W-1:0] FLOOR_TARGET_RST    = -16'sd123;
    localparam logic signed [REG_W-1:0] SHOOT_TARGET_RST    = -16'sd655;
    localparam logic signed [REG_W-1:0] CLIMB_TARGET_RST    = -16'sd955;
    localparam logic signed [REG_W-1:0] TRAVERSE_TARGET_RST = -16'sd406;
    localparam logic signed [REG_W-1:0] FLOOR_CUTOFF_RST    = -16'sd125;
    localparam logic [TOL_W-1:0]        LOCK_TOLERANCE_RST  = 12'd205;

    // Integer cube root search: root r is capped at 2^17 - 1, so the
    // rounded half-root (r + 1) >> 1 is capped at 65536.
    localparam int ROOT_W = 17;
    localparam int BIT_W  = 5;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int CU_W   = 3 * ROOT_W;
    localparam int LHS_W  = CU_W + 7;

    // Drive output
    localparam int DRIVE_W = 16;
    localparam logic [DRIVE_W-1:0] DRIVE_POS_MAX = 16'h7FFF;

endpackage

`default_nettype wire

[rtl/arm_cube_root_position_drive.sv]
// Arm position drive: error to target, signed cube-root response, lock flag.
// Depends on acrpd_pkg and arm_cube_root_position_drive_assert.svh.
// An accepted request occupies the block: idle registers the error, then each
// of the 17 root bits passes through the square, cube, scale-by-100 and
// compare states on one shared 34x17 multiplier, and the finish state
// forms the drive and lock flag. The result then sits in the output
// register; the next request is taken as soon as the block is back in idle,
// which needs the previous result to have left the output register.
`default_nettype none

module arm_cube_root_position_drive #(
    parameter int POS_WIDTH = 16,
    parameter int FRAC_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [acrpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [acrpd_pkg::REG_W-1:0]       cfg_data,
    // input request channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        target_select,
    input  wire logic signed [POS_WIDTH-1:0]       arm_position,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [acrpd_pkg::DRIVE_W-1:0]   motor_drive,
    output logic                                   motor_zeroed,
    output logic                                   lock_engaged
);
    import acrpd_pkg::*;

`include "arm_cube_root_position_drive_assert.svh"

    localparam int ERR_W = ((POS_WIDTH > REG_W) ? POS_WIDTH : REG_W) + 1;
    localparam int SH    = 3 * FRAC_BITS + 3;
    localparam int X_W   = ERR_W + SH;
    localparam int CMP_W = (X_W > LHS_W) ? X_W : LHS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CU,
        ST_SCALE,
        ST_CMP,
        ST_FIN
    } state_t;

    // Configuration registers
    logic signed [REG_W-1:0] floor_target_reg;
    logic signed [REG_W-1:0] shoot_target_reg;
    logic signed [REG_W-1:0] climb_target_reg;
    logic signed [REG_W-1:0] traverse_target_reg;
    logic signed [REG_W-1:0] floor_cutoff_reg;
    logic [TOL_W-1:0]        lock_tolerance_reg;

    // Datapath and control registers
    state_t                  state_reg, state_next;
    logic [ERR_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic                    zeroed_reg, zeroed_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [CU_W-1:0]         cu_reg, cu_next;
    logic [LHS_W-1:0]        lhs_reg, lhs_next;
    logic                    lock_reg, lock_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]      drive_reg, drive_next;
    logic                    zero_out_reg, zero_out_next;
    logic                    lock_out_reg, lock_out_next;

    // Combinational helpers
    logic signed [REG_W-1:0] target_mux;
    logic signed [ERR_W-1:0] err;
    logic [ROOT_W-1:0]       cand;
    logic [SQ_W-1:0]         mul_a;
    logic [CU_W-1:0]         product;
    logic [CMP_W-1:0]        x_ext;
    logic [CMP_W-1:0]        lhs_ext;
    logic                    fits;
    logic [ROOT_W:0]         m_sum;
    logic [ROOT_W-1:0]       m_val;
    logic [ROOT_W:0]         h_sum;
    logic [ROOT_W-1:0]       h_val;
    logic [DRIVE_W-1:0]      drive_val;
    logic [ROOT_W-1:0]       absd;
    logic                    out_free;
    logic                    accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_target_reg    <= FLOOR_TARGET_RST;
            shoot_target_reg    <= SHOOT_TARGET_RST;
            climb_target_reg    <= CLIMB_TARGET_RST;
            traverse_target_reg <= TRAVERSE_TARGET_RST;
            floor_cutoff_reg    <= FLOOR_CUTOFF_RST;
            lock_tolerance_reg  <= LOCK_TOLERANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FLOOR_TARGET:    floor_target_reg    <= cfg_data;
                CFG_SHOOT_TARGET:    shoot_target_reg    <= cfg_data;
                CFG_CLIMB_TARGET:    climb_target_reg    <= cfg_data;
                CFG_TRAVERSE_TARGET: traverse_target_reg <= cfg_data;
                CFG_FLOOR_CUTOFF:    floor_cutoff_reg    <= cfg_data;
                CFG_LOCK_TOLERANCE:  lock_tolerance_reg  <= cfg_data[TOL_W-1:0];
                default:             ;
            endcase
        end
    end

    // Select the target for this request
    always_comb
    begin
        case (target_select)
            SEL_FLOOR:    target_mux = floor_target_reg;
            SEL_SHOOT:    target_mux = shoot_target_reg;
            SEL_CLIMB:    target_mux = climb_target_reg;
            SEL_TRAVERSE: target_mux = traverse_target_reg;
            default:      target_mux = floor_target_reg;
        endcase
    end

    assign err = ERR_W'(arm_position) - ERR_W'(target_mux);

    // Shared multiplier: candidate squared, then square times candidate
    assign cand    = root_reg | (ROOT_W'(1) << bit_reg);
    assign mul_a   = (state_reg == ST_SQ) ? SQ_W'(cand) : sq_reg;
    assign product = CU_W'(mul_a) * CU_W'(cand);

    // Compare candidate cube times 100 against |error| scaled by 2^SH
    assign x_ext   = CMP_W'({mag_reg, {SH{1'b0}}});
    assign lhs_ext = CMP_W'(lhs_reg);
    assign fits    = (lhs_ext <= x_ext);

    // Round the root to the half-step and halve negative drive
    assign m_sum = {1'b0, root_reg} + (ROOT_W+1)'(1);
    assign m_val = m_sum[ROOT_W:1];
    assign h_sum = {1'b0, m_val} + (ROOT_W+1)'(1);
    assign h_val = h_sum[ROOT_W:1];

    always_comb
    begin
        if (neg_reg)
        begin
            absd      = h_val;
            drive_val = DRIVE_W'(~h_val + ROOT_W'(1));
        end
        else if (m_val > ROOT_W'(DRIVE_POS_MAX))
        begin
            absd      = ROOT_W'(DRIVE_POS_MAX);
            drive_val = DRIVE_POS_MAX;
        end
        else
        begin
            absd      = m_val;
            drive_val = m_val[DRIVE_W-1:0];
        end
    end

    // Sequencer: next-state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        zeroed_next    = zeroed_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        sq_next        = sq_reg;
        cu_next        = cu_reg;
        lhs_next       = lhs_reg;
        lock_next      = lock_reg;
        out_valid_next = out_valid_reg && out_stall;
        drive_next     = drive_reg;
        zero_out_next  = zero_out_reg;
        lock_out_next  = lock_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next    = err[ERR_W-1];
                    mag_next    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
                    zeroed_next = (target_select == SEL_FLOOR) &&
                                  (ERR_W'(arm_position) > ERR_W'(floor_cutoff_reg));
                    root_next   = '0;
                    bit_next    = BIT_W'(ROOT_W - 1);
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                sq_next    = product[SQ_W-1:0];
                state_next = ST_CU;
            end
            ST_CU:
            begin
                cu_next    = product;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                lhs_next   = (LHS_W'(cu_reg) << 6) + (LHS_W'(cu_reg) << 5) +
                             (LHS_W'(cu_reg) << 2);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (fits)
                begin
                    root_next = cand;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = ST_SQ;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    lock_next      = lock_reg || (absd < ROOT_W'(lock_tolerance_reg));
                    drive_next     = zeroed_reg ? '0 : drive_val;
                    zero_out_next  = zeroed_reg;
                    lock_out_next  = lock_reg || (absd < ROOT_W'(lock_tolerance_reg));
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, datapath and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lock_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            zeroed_reg    <= 1'b0;
            root_reg      <= '0;
            bit_reg       <= '0;
            sq_reg        <= '0;
            cu_reg        <= '0;
            lhs_reg       <= '0;
            drive_reg     <= '0;
            zero_out_reg  <= 1'b0;
            lock_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lock_reg      <= lock_next;
            out_valid_reg <= out_valid_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            zeroed_reg    <= zeroed_next;
            root_reg      <= root_next;
            bit_reg       <= bit_next;
            sq_reg        <= sq_next;
            cu_reg        <= cu_next;
            lhs_reg       <= lhs_next;
            drive_reg     <= drive_next;
            zero_out_reg  <= zero_out_next;
            lock_out_reg  <= lock_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign motor_drive  = drive_reg;
    assign motor_zeroed = zero_out_reg;
    assign lock_engaged = lock_out_reg;

    // Checks
    `ACRPD_ASSERT_NEXT(a_lock_sticky, lock_reg, lock_reg,
        "lock flag cleared outside reset")
    `ACRPD_ASSERT_NEXT(a_accept_starts_search, accept,
        (state_reg == ST_SQ) && (root_reg == '0),
        "accepted request did not start a fresh root search")
    `ACRPD_ASSERT_SAME(a_result_from_finish, $rose(out_valid_reg),
        $past(state_reg) == ST_FIN,
        "result appeared without finishing a search")
    `ACRPD_ASSERT_SAME(a_zeroed_drive, out_valid_reg && zero_out_reg,
        drive_reg == '0,
        "floor cutoff result carries nonzero drive")

endmodule

`default_nettype wire

[tb/sv/arm_drive_checker.sv]
`timescale 1ns / 1ps
// Result checker for the arm cube-root position drive: follows register writes,
// predicts every drive result and compares it with what the block returns.
// Depends on acrpd_pkg for register indexes, select codes and reset values.

module arm_drive_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [acrpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acrpd_pkg::REG_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [1:0]                           target_select,
    input  logic signed [15:0]                   arm_position,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [acrpd_pkg::DRIVE_W-1:0] motor_drive,
    input  logic                                 motor_zeroed,
    input  logic                                 lock_engaged,
    output int                                   mismatch_count,
    output int                                   pending,
    output int                                   checked
);

    import acrpd_pkg::*;

    localparam int FRAC_BITS = 12;
    localparam int ROOT_SHIFT = 3 * FRAC_BITS + 3;
    localparam longint unsigned ROOT_LIMIT = 65536;
    localparam longint unsigned SCALE_DIVISOR = 100;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      zeroed;
        logic                      lock;
    } drive_result_t;

    // Register copies and the sticky lock flag
    logic signed [REG_W-1:0] target_reg [4];
    logic signed [REG_W-1:0] cutoff_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic                    lock_state;

    drive_result_t drive_expect_q [$];
    int mismatch_total;
    int checked_total;

    task automatic report_mismatch(input string msg);
        if (mismatch_total < MAX_REPORTS)
        begin
            $display("[%0t] drive result %0d: %s", $time, checked_total, msg);
        end
        mismatch_total++;
    endtask

    // Round-to-nearest cube root of mag/100 with FRAC_BITS fraction bits
    function automatic longint unsigned cube_root_q(input longint unsigned mag);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        longint unsigned lhs;
        lo = 0;
        hi = ROOT_LIMIT;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo + 1) >> 1);
            odd = 2 * mid - 1;
            lhs = odd * odd * odd * SCALE_DIVISOR;
            if (lhs <= (mag << ROOT_SHIFT))
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic drive_result_t predict_drive(input logic [1:0] sel,
                                                    input logic signed [15:0] pos);
        drive_result_t   res;
        int              err;
        int              drive;
        int              drive_mag;
        longint unsigned mag;
        longint unsigned root;
        longint unsigned half;
        err = int'(pos) - int'(target_reg[sel]);
        if (err < 0)
            mag = -err;
        else
            mag = err;
        root = cube_root_q(mag);
        // halve a negative drive, ties away from zero
        if (err < 0)
        begin
            half = (root + 1) >> 1;
            if (half > 32768)
                half = 32768;
            drive = -int'(half);
        end
        else
        begin
            if (root > 32767)
                root = 32767;
            drive = int'(root);
        end
        drive_mag = (drive < 0) ? -drive : drive;
        // lock looks at the drive before floor zeroing
        res.lock = lock_state || (drive_mag < int'(tol_reg));
        res.zeroed = (sel == SEL_FLOOR) && (pos > cutoff_reg);
        res.drive = res.zeroed ? '0 : 16'(drive);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_result_t want;
        if (!rst_n)
        begin
            target_reg[SEL_FLOOR]    = FLOOR_TARGET_RST;
            target_reg[SEL_SHOOT]    = SHOOT_TARGET_RST;
            target_reg[SEL_CLIMB]    = CLIMB_TARGET_RST;
            target_reg[SEL_TRAVERSE] = TRAVERSE_TARGET_RST;
            cutoff_reg = FLOOR_CUTOFF_RST;
            tol_reg = LOCK_TOLERANCE_RST;
            lock_state = 1'b0;
            drive_expect_q.delete();
            mismatch_total = 0;
            checked_total = 0;
            mismatch_count <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            // track register writes; unused indexes change nothing
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < CFG_FLOOR_CUTOFF)
                    target_reg[cfg_index[1:0]] = cfg_data;
                else if (cfg_index == CFG_FLOOR_CUTOFF)
                    cutoff_reg = cfg_data;
                else if (cfg_index == CFG_LOCK_TOLERANCE)
                    tol_reg = cfg_data[TOL_W-1:0];
            end

            // compare a returned result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no request waiting (drive %0d)",
                                              motor_drive));
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    if (motor_drive !== want.drive)
                        report_mismatch($sformatf("motor_drive is %0d, expected %0d",
                                                  motor_drive, want.drive));
                    if (motor_zeroed !== want.zeroed)
                        report_mismatch($sformatf("motor_zeroed is %b, expected %b",
                                                  motor_zeroed, want.zeroed));
                    if (lock_engaged !== want.lock)
                        report_mismatch($sformatf("lock_engaged is %b, expected %b",
                                                  lock_engaged, want.lock));
                    checked_total++;
                end
            end

            // predict each accepted request
            if (in_valid && !in_stall)
            begin
                want = predict_drive(target_select, arm_position);
                lock_state = want.lock;
                drive_expect_q.push_back(want);
            end

            mismatch_count <= mismatch_total;
            pending <= drive_expect_q.size();
            checked <= checked_total;
        end
    end

endmodule

[tb/sv/arm_cube_root_position_drive_tb.sv]
`timescale 1ns / 1ps
// Top of the arm cube-root position drive testbench: clock, reset, register
// writes, request and stall stimulus, and the verdict.
// Depends on acrpd_pkg, arm_cube_root_position_drive and arm_drive_checker.

module arm_cube_root_position_drive_tb;

    import acrpd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_REQUESTS = 300;
    localparam int SETTLE_CYCLES = 100;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [REG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 target_select = '0;
    logic signed [15:0]         arm_position = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [DRIVE_W-1:0]  motor_drive;
    logic                       motor_zeroed;
    logic                       lock_engaged;

    int mismatch_count;
    int pending;
    int checked;
    int request_total = 0;
    int write_total = 0;
    bit quiet = 1'b0;

    logic signed [REG_W-1:0] target_shadow [4];
    logic signed [REG_W-1:0] cutoff_shadow;

    arm_cube_root_position_drive i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .target_select (target_select),
        .arm_position  (arm_position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_drive   (motor_drive),
        .motor_zeroed  (motor_zeroed),
        .lock_engaged  (lock_engaged)
    );

    arm_drive_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_select  (target_select),
        .arm_position   (arm_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .motor_drive    (motor_drive),
        .motor_zeroed   (motor_zeroed),
        .lock_engaged   (lock_engaged),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .checked        (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up long after the slowest correct run would have finished
    initial
    begin
        #25_000_000;
        $display("Timeout with %0d results still outstanding", pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Mostly short gaps, a few long ones, none while quiet
    function automatic int pick_idle();
        int pick;
        if (quiet)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 100);
    endfunction

    // Stall the result side in random stretches
    initial
    begin : result_stall
        int hold;
        int pick;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    out_stall <= 1'b0;
                    hold = $urandom_range(0, 6);
                end
                else if (pick < 90)
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(0, 4);
                end
                else
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(20, 100);
                end
            end
        end
    end

    // Present one request and hold it until taken; valid stays high afterwards
    task automatic send_request(input logic [1:0] sel, input logic signed [15:0] pos);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        target_select <= sel;
        arm_position <= pos;
        do @(posedge clk); while (in_stall);
        request_total++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write one register; drop valid only after the final write of a batch
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] value, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        if (idx < CFG_FLOOR_CUTOFF)
            target_shadow[idx[1:0]] = value;
        else if (idx == CFG_FLOOR_CUTOFF)
            cutoff_shadow = value;
        write_total++;
    endtask

    function automatic logic [REG_W-1:0] pick_register_value(input logic [CFG_IDX_W-1:0] idx);
        int pick;
        pick = $urandom_range(0, 9);
        // upper bits of a tolerance write must be dropped by the block
        if (idx == CFG_LOCK_TOLERANCE)
        begin
            if (pick == 0)
                return {4'($urandom), 12'h000};
            if (pick == 1)
                return {4'($urandom), 12'hFFF};
            return 16'($urandom);
        end
        case (pick)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic randomize_registers();
        logic [CFG_IDX_W-1:0] idx;
        if ($urandom_range(0, 1))
            write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                           16'($urandom), 1'b0);
        for (int i = 0; i <= int'(CFG_LOCK_TOLERANCE); i++)
        begin
            idx = CFG_IDX_W'(i);
            write_register(idx, pick_register_value(idx), idx == CFG_LOCK_TOLERANCE);
        end
    endtask

    initial
    begin : stimulus
        logic [1:0]         sel;
        logic signed [15:0] pos;
        int                 pick;
        int                 offset;

        target_shadow[SEL_FLOOR]    = FLOOR_TARGET_RST;
        target_shadow[SEL_SHOOT]    = SHOOT_TARGET_RST;
        target_shadow[SEL_CLIMB]    = CLIMB_TARGET_RST;
        target_shadow[SEL_TRAVERSE] = TRAVERSE_TARGET_RST;
        cutoff_shadow = FLOOR_CUTOFF_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: field extremes, floor cutoff edges, error of one
        send_request(SEL_FLOOR, 16'sh7FFF);
        send_request(SEL_FLOOR, -16'sd125);
        send_request(SEL_FLOOR, -16'sd124);
        send_request(SEL_SHOOT, 16'sh8000);
        send_request(SEL_CLIMB, 16'sh7FFF);
        send_request(SEL_TRAVERSE, 16'sh8000);
        send_request(SEL_SHOOT, -16'sd654);
        send_request(SEL_SHOOT, -16'sd656);

        // Largest errors both ways, zero error with zero tolerance
        drain_results();
        write_register(CFG_SPARE_LO, 16'h5A5A, 1'b0);
        write_register(CFG_SPARE_HI, 16'hA5A5, 1'b0);
        write_register(CFG_FLOOR_TARGET, 16'h8000, 1'b0);
        write_register(CFG_SHOOT_TARGET, 16'h7FFF, 1'b0);
        write_register(CFG_CLIMB_TARGET, 16'h0000, 1'b0);
        write_register(CFG_TRAVERSE_TARGET, 16'h8000, 1'b0);
        write_register(CFG_FLOOR_CUTOFF, 16'h7FFF, 1'b0);
        write_register(CFG_LOCK_TOLERANCE, 16'hF000, 1'b1);
        send_request(SEL_FLOOR, 16'sh7FFF);
        send_request(SEL_SHOOT, 16'sh8000);
        send_request(SEL_CLIMB, 16'sh0000);
        send_request(SEL_TRAVERSE, 16'sh8000);

        // Lowest cutoff, widest tolerance: lock engages on a zeroed request
        drain_results();
        write_register(CFG_FLOOR_TARGET, 16'h0000, 1'b0);
        write_register(CFG_FLOOR_CUTOFF, 16'h8000, 1'b0);
        write_register(CFG_LOCK_TOLERANCE, 16'h0FFF, 1'b1);
        send_request(SEL_FLOOR, -16'sd32767);
        send_request(SEL_FLOOR, 16'sh8000);
        send_request(SEL_FLOOR, 16'sd1);
        send_request(SEL_SHOOT, 16'sh7FFF);

        // Random phases, each under fresh register settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            randomize_registers();
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (n % 100 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                sel = 2'($urandom_range(0, 3));
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    pos = 16'($urandom);
                end
                else if (pick < 80)
                begin
                    offset = $urandom_range(0, 800);
                    pos = 16'(int'(target_shadow[sel]) + offset - 400);
                end
                else if (pick < 92)
                begin
                    sel = SEL_FLOOR;
                    offset = $urandom_range(0, 6);
                    pos = 16'(int'(cutoff_shadow) + offset - 3);
                end
                else
                begin
                    pos = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
                send_request(sel, pos);
            end
        end

        // Wait for the last results, then let the block settle
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d drive results from %0d requests", checked, request_total);
        $display("Made %0d register writes, targets, cutoff and tolerance at both extremes",
                 write_total);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
